[sv/pfi_pkg.sv]
`timescale 1ns / 1ps

package pfi_pkg;

	// Unsigned 0.53 fractions: one whole is bit 53.
	localparam logic [53:0] ONE53  = 54'h20_0000_0000_0000;
	localparam logic [53:0] HALF53 = 54'h10_0000_0000_0000;

	// SplitMix64 constants used to expand the seed into the generator words.
	localparam logic [63:0] GOLDEN = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [63:0] MIX1   = 64'hbf58_476d_1ce4_e5b9;
	localparam logic [63:0] MIX2   = 64'h94d0_49bb_1331_11eb;

	// Input mode codes.
	localparam logic [1:0] MODE_BYTE  = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_WRITE = 2'd2;

	// Write plan verdict codes.
	localparam logic [1:0] VERDICT_PROCEED = 2'd0;
	localparam logic [1:0] VERDICT_FAIL    = 2'd1;
	localparam logic [1:0] VERDICT_SKIP    = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_SEED      = 3'd0;
	localparam logic [2:0] REG_FLIP      = 3'd1;
	localparam logic [2:0] REG_SHORT     = 3'd2;
	localparam logic [2:0] REG_MIN_RATIO = 3'd3;
	localparam logic [2:0] REG_FAIL      = 3'd4;
	localparam logic [2:0] REG_LIE       = 3'd5;
	localparam logic [2:0] REG_PARTIAL   = 3'd6;

	typedef enum logic [1:0] {
		OP_BYTE  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Classified command header as it travels through the queue.
	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       fin;
	} cmd_hdr_t;

	typedef struct packed {
		logic [53:0] thr_flip;
		logic [53:0] thr_short;
		logic [53:0] min_ratio;
		logic [53:0] thr_fail;
		logic [53:0] thr_lie;
		logic [53:0] thr_part;
	} cfg_t;

	typedef struct packed {
		logic        load;
		logic [63:0] value;
	} seed_req_t;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic         done;
		logic [127:0] prod;
	} mul_rsp_t;

	typedef logic [3:0][63:0] gen_t;

	// Clamp the low 54 bits of a written value to a 0.53 fraction no larger than one.
	function automatic logic [53:0] sat_frac(input logic [63:0] v);
		logic [53:0] f;
		f = v[53:0];
		return (f > ONE53) ? ONE53 : f;
	endfunction

	// Output scrambler of xoshiro256**: rotl(s1 * 5, 7) * 9.
	function automatic logic [63:0] xo_out(input logic [63:0] s1);
		logic [63:0] x5;
		logic [63:0] r;
		x5 = s1 + {s1[61:0], 2'b00};
		r  = {x5[56:0], x5[63:57]};
		return r + {r[60:0], 3'b000};
	endfunction

	// One state advance of xoshiro256**.
	function automatic gen_t xo_next(input gen_t s);
		gen_t        n;
		logic [63:0] t;
		t    = {s[1][46:0], 17'd0};
		n[2] = s[2] ^ s[0];
		n[3] = s[3] ^ s[1];
		n[1] = s[1] ^ n[2];
		n[0] = s[0] ^ n[3];
		n[2] = n[2] ^ t;
		n[3] = {n[3][18:0], n[3][63:19]};
		return n;
	endfunction

endpackage

[sv/pfi_mul.sv]
`timescale 1ns / 1ps

// 64 x 64 to 128 bit multiplier built from four 32 x 32 partial products,
// one per cycle, each registered before it is accumulated.
module pfi_mul (
	input  logic             clk,
	input  logic             arst_n,
	input  pfi_pkg::mul_req_t req,
	output pfi_pkg::mul_rsp_t rsp
);

	logic [63:0]  a_q;
	logic [63:0]  b_q;
	logic [1:0]   step_q;
	logic         busy_q;
	logic [63:0]  pp_q;
	logic [1:0]   pp_idx_q;
	logic         pp_valid_q;
	logic [127:0] acc_q;
	logic         done_q;

	logic [31:0]  a_half;
	logic [31:0]  b_half;
	logic [127:0] pp_shifted;

	assign a_half = step_q[1] ? a_q[63:32] : a_q[31:0];
	assign b_half = step_q[0] ? b_q[63:32] : b_q[31:0];

	always_comb begin
		case (pp_idx_q)
			2'd0:       pp_shifted = {64'd0, pp_q};
			2'd1, 2'd2: pp_shifted = {32'd0, pp_q, 32'd0};
			default:    pp_shifted = {pp_q, 64'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			pp_valid_q <= 1'b0;
			done_q     <= 1'b0;
			step_q     <= 2'd0;
		end else if (req.start) begin
			busy_q     <= 1'b1;
			pp_valid_q <= 1'b0;
			done_q     <= 1'b0;
			step_q     <= 2'd0;
		end else begin
			pp_valid_q <= busy_q;
			done_q     <= pp_valid_q && (pp_idx_q == 2'd3);
			if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else begin
			if (busy_q) begin
				pp_q     <= 64'(a_half * b_half);
				pp_idx_q <= step_q;
			end
			if (pp_valid_q) begin
				acc_q <= acc_q + pp_shifted;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

[sv/pfi_fifo.sv]
`timescale 1ns / 1ps

// Short command queue between the front and the back.
module pfi_fifo #(
	parameter int WIDTH = 35,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue popped while empty");

	a_count_push: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a push");
`endif

endmodule

[sv/pfi_front.sv]
`timescale 1ns / 1ps

// Front: configuration registers and classification of incoming items.
module pfi_front #(
	parameter int LENGTH_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             mode,
	input  logic [7:0]             data_byte,
	input  logic                   final_byte,
	input  logic [LENGTH_BITS-1:0] length,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [2:0]             cfg_index,
	input  logic [63:0]            cfg_data,
	output logic                   push,
	output logic [$bits(pfi_pkg::cmd_hdr_t)+LENGTH_BITS-1:0] push_data,
	input  logic                   full,
	output pfi_pkg::cfg_t          cfg,
	output pfi_pkg::seed_req_t     seed_req
);

	pfi_pkg::cfg_t     cfg_q;
	pfi_pkg::cmd_hdr_t hdr;
	logic              cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr_flip  <= '0;
			cfg_q.thr_short <= '0;
			cfg_q.min_ratio <= pfi_pkg::HALF53;
			cfg_q.thr_fail  <= '0;
			cfg_q.thr_lie   <= '0;
			cfg_q.thr_part  <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				pfi_pkg::REG_FLIP:      cfg_q.thr_flip  <= pfi_pkg::sat_frac(cfg_data);
				pfi_pkg::REG_SHORT:     cfg_q.thr_short <= pfi_pkg::sat_frac(cfg_data);
				pfi_pkg::REG_MIN_RATIO: cfg_q.min_ratio <= pfi_pkg::sat_frac(cfg_data);
				pfi_pkg::REG_FAIL:      cfg_q.thr_fail  <= pfi_pkg::sat_frac(cfg_data);
				pfi_pkg::REG_LIE:       cfg_q.thr_lie   <= pfi_pkg::sat_frac(cfg_data);
				pfi_pkg::REG_PARTIAL:   cfg_q.thr_part  <= pfi_pkg::sat_frac(cfg_data);
				default: ;
			endcase
		end
	end

	// The seed itself is not kept; a write only restarts the expansion.
	assign seed_req.load  = cfg_wr && (cfg_index == pfi_pkg::REG_SEED);
	assign seed_req.value = cfg_data;
	assign cfg            = cfg_q;

	always_comb begin
		hdr.data = data_byte;
		hdr.fin  = final_byte;
		case (mode)
			pfi_pkg::MODE_BYTE:  hdr.op = pfi_pkg::OP_BYTE;
			pfi_pkg::MODE_READ:  hdr.op = pfi_pkg::OP_READ;
			pfi_pkg::MODE_WRITE: hdr.op = pfi_pkg::OP_WRITE;
			default:             hdr.op = pfi_pkg::OP_NONE;
		endcase
	end

	assign in_ready  = !full;
	assign push      = in_valid && !full;
	assign push_data = {hdr, length};

endmodule

[sv/pfi_back.sv]
`timescale 1ns / 1ps

// Back: generator state, seed expansion, fault sequencing and the result
// register.
module pfi_back #(
	parameter int LENGTH_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pfi_pkg::cfg_t          cfg,
	input  pfi_pkg::seed_req_t     seed_req,
	input  logic                   empty,
	output logic                   pop,
	input  logic [$bits(pfi_pkg::cmd_hdr_t)+LENGTH_BITS-1:0] pop_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             out_byte,
	output logic                   flipped,
	output logic [2:0]             flip_bit,
	output logic                   final_out,
	output logic [LENGTH_BITS-1:0] actual_length,
	output logic [1:0]             write_verdict
);

	typedef enum logic [10:0] {
		S_SEED_ADD   = 11'b000_0000_0001,
		S_SEED_M1    = 11'b000_0000_0010,
		S_SEED_M2    = 11'b000_0000_0100,
		S_IDLE       = 11'b000_0000_1000,
		S_TEST       = 11'b000_0001_0000,
		S_FLIP       = 11'b000_0010_0000,
		S_RATIO_DRAW = 11'b000_0100_0000,
		S_MUL_RATIO  = 11'b000_1000_0000,
		S_PART_DRAW  = 11'b001_0000_0000,
		S_MUL_LEN    = 11'b010_0000_0000,
		S_DONE       = 11'b100_0000_0000
	} bstate_t;

	typedef enum logic [1:0] {
		WS_FAIL = 2'd0,
		WS_LIE  = 2'd1,
		WS_PART = 2'd2
	} wstep_t;

	bstate_t state_q, state_d;
	wstep_t  sub_q, sub_d;

	pfi_pkg::gen_t gen_q, gen_d;
	logic [63:0]   res_q;
	logic [63:0]   sm_q, sm_d;
	logic [1:0]    idx_q, idx_d;

	pfi_pkg::op_t           op_q, op_d;
	logic [7:0]             byte_q, byte_d;
	logic                   fin_q, fin_d;
	logic [LENGTH_BITS-1:0] len_q, len_d;
	logic [7:0]             obyte_q, obyte_d;
	logic                   flip_q, flip_d;
	logic [2:0]             fbit_q, fbit_d;
	logic [LENGTH_BITS-1:0] alen_q, alen_d;
	logic [1:0]             verdict_q, verdict_d;

	logic                   out_valid_q;
	logic [7:0]             out_byte_q;
	logic                   out_flip_q;
	logic [2:0]             out_fbit_q;
	logic                   out_fin_q;
	logic [LENGTH_BITS-1:0] out_alen_q;
	logic [1:0]             out_verdict_q;

	pfi_pkg::mul_req_t mreq;
	pfi_pkg::mul_rsp_t mrsp;
	pfi_pkg::cmd_hdr_t hdr_in;
	logic [LENGTH_BITS-1:0] len_in;

	logic [52:0]            frac;
	logic [53:0]            thr_sel;
	logic                   thr_nz;
	logic                   hit;
	logic                   draw;
	logic                   out_free;
	logic                   out_load;
	logic                   load_cmd;
	logic [63:0]            sm_next;
	logic [63:0]            z_prod;
	logic [53:0]            ratio;
	logic [LENGTH_BITS-1:0] t_len;
	logic [LENGTH_BITS-1:0] t_min1;
	logic [63:0]            len_ext;

	pfi_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	assign {hdr_in, len_in} = pop_data;

	assign frac    = res_q[63:11];
	assign sm_next = sm_q + pfi_pkg::GOLDEN;
	assign z_prod  = mrsp.prod[63:0];
	assign ratio   = cfg.min_ratio + mrsp.prod[106:53];
	assign t_len   = mrsp.prod[53 +: LENGTH_BITS];
	assign t_min1  = (t_len == '0) ? LENGTH_BITS'(1) : t_len;
	assign len_ext = {{(64 - LENGTH_BITS){1'b0}}, len_q};

	always_comb begin
		case (op_q)
			pfi_pkg::OP_BYTE:  thr_sel = cfg.thr_flip;
			pfi_pkg::OP_READ:  thr_sel = cfg.thr_short;
			pfi_pkg::OP_WRITE: begin
				case (sub_q)
					WS_FAIL: thr_sel = cfg.thr_fail;
					WS_LIE:  thr_sel = cfg.thr_lie;
					default: thr_sel = cfg.thr_part;
				endcase
			end
			default: thr_sel = '0;
		endcase
	end

	assign thr_nz = (thr_sel != '0);
	assign hit    = thr_nz && ({1'b0, frac} < thr_sel);
	assign draw   = ((state_q == S_TEST) && thr_nz) || (state_q == S_FLIP) ||
		(state_q == S_RATIO_DRAW) || (state_q == S_PART_DRAW);

	assign out_free = !out_valid_q || out_ready;
	assign out_load = (state_q == S_DONE) && out_free;
	assign load_cmd = !empty && ((state_q == S_IDLE) || out_load);
	assign pop      = load_cmd && !seed_req.load;

	always_comb begin
		state_d   = state_q;
		sub_d     = sub_q;
		sm_d      = sm_q;
		idx_d     = idx_q;
		op_d      = op_q;
		byte_d    = byte_q;
		fin_d     = fin_q;
		len_d     = len_q;
		obyte_d   = obyte_q;
		flip_d    = flip_q;
		fbit_d    = fbit_q;
		alen_d    = alen_q;
		verdict_d = verdict_q;
		mreq      = '0;
		gen_d     = draw ? pfi_pkg::xo_next(gen_q) : gen_q;

		case (state_q)
			S_SEED_ADD: begin
				sm_d       = sm_next;
				mreq.start = 1'b1;
				mreq.a     = sm_next ^ (sm_next >> 30);
				mreq.b     = pfi_pkg::MIX1;
				state_d    = S_SEED_M1;
			end
			S_SEED_M1: begin
				if (mrsp.done) begin
					mreq.start = 1'b1;
					mreq.a     = z_prod ^ (z_prod >> 27);
					mreq.b     = pfi_pkg::MIX2;
					state_d    = S_SEED_M2;
				end
			end
			S_SEED_M2: begin
				if (mrsp.done) begin
					gen_d[idx_q] = z_prod ^ (z_prod >> 31);
					idx_d        = idx_q + 2'd1;
					state_d      = (idx_q == 2'd3) ? S_IDLE : S_SEED_ADD;
				end
			end
			S_IDLE: ;
			S_TEST: begin
				case (op_q)
					pfi_pkg::OP_BYTE:  state_d = hit ? S_FLIP : S_DONE;
					pfi_pkg::OP_READ:  state_d = hit ? S_RATIO_DRAW : S_DONE;
					pfi_pkg::OP_WRITE: begin
						case (sub_q)
							WS_FAIL: begin
								if (hit) begin
									verdict_d = pfi_pkg::VERDICT_FAIL;
									state_d   = S_DONE;
								end else begin
									sub_d = WS_LIE;
								end
							end
							WS_LIE: begin
								if (hit) begin
									verdict_d = pfi_pkg::VERDICT_SKIP;
									state_d   = S_DONE;
								end else begin
									sub_d = WS_PART;
								end
							end
							default: begin
								alen_d  = len_q;
								state_d = hit ? S_PART_DRAW : S_DONE;
							end
						endcase
					end
					default: state_d = S_DONE;
				endcase
			end
			S_FLIP: begin
				fbit_d  = res_q[2:0];
				obyte_d = obyte_q ^ (8'd1 << res_q[2:0]);
				flip_d  = 1'b1;
				state_d = S_DONE;
			end
			S_RATIO_DRAW: begin
				mreq.start = 1'b1;
				mreq.a     = {11'd0, frac};
				mreq.b     = {10'd0, pfi_pkg::ONE53 - cfg.min_ratio};
				state_d    = S_MUL_RATIO;
			end
			S_MUL_RATIO: begin
				if (mrsp.done) begin
					mreq.start = 1'b1;
					mreq.a     = len_ext;
					mreq.b     = {10'd0, ratio};
					state_d    = S_MUL_LEN;
				end
			end
			S_PART_DRAW: begin
				mreq.start = 1'b1;
				mreq.a     = len_ext;
				mreq.b     = {11'd0, frac};
				state_d    = S_MUL_LEN;
			end
			S_MUL_LEN: begin
				if (mrsp.done) begin
					if (op_q == pfi_pkg::OP_READ) begin
						alen_d = (t_min1 > len_q) ? len_q : t_min1;
					end else begin
						alen_d = t_min1;
					end
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		if (pop) begin
			op_d      = hdr_in.op;
			byte_d    = hdr_in.data;
			fin_d     = hdr_in.fin;
			len_d     = len_in;
			sub_d     = WS_FAIL;
			obyte_d   = (hdr_in.op == pfi_pkg::OP_BYTE) ? hdr_in.data : 8'd0;
			flip_d    = 1'b0;
			fbit_d    = 3'd0;
			alen_d    = (hdr_in.op == pfi_pkg::OP_READ) ? len_in : '0;
			verdict_d = pfi_pkg::VERDICT_PROCEED;
			state_d   = S_TEST;
		end

		if (seed_req.load) begin
			sm_d    = seed_req.value;
			idx_d   = 2'd0;
			state_d = S_SEED_ADD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SEED_ADD;
			sm_q        <= '0;
			idx_q       <= 2'd0;
			sub_q       <= WS_FAIL;
			op_q        <= pfi_pkg::OP_NONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			sm_q        <= sm_d;
			idx_q       <= idx_d;
			sub_q       <= sub_d;
			op_q        <= op_d;
			out_valid_q <= out_load || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		gen_q     <= gen_d;
		res_q     <= pfi_pkg::xo_out(gen_d[1]);
		byte_q    <= byte_d;
		fin_q     <= fin_d;
		len_q     <= len_d;
		obyte_q   <= obyte_d;
		flip_q    <= flip_d;
		fbit_q    <= fbit_d;
		alen_q    <= alen_d;
		verdict_q <= verdict_d;
		if (out_load) begin
			out_byte_q    <= obyte_q;
			out_flip_q    <= flip_q;
			out_fbit_q    <= fbit_q;
			out_fin_q     <= fin_q;
			out_alen_q    <= alen_q;
			out_verdict_q <= verdict_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign flipped       = out_flip_q;
	assign flip_bit      = out_fbit_q;
	assign final_out     = out_fin_q;
	assign actual_length = out_alen_q;
	assign write_verdict = out_verdict_q;

`ifndef SYNTHESIS
	a_flip_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_flip_q) |->
			((out_verdict_q == pfi_pkg::VERDICT_PROCEED) && (out_alen_q == '0)))
		else $error("flipped byte carries plan fields");

	a_verdict_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_verdict_q != pfi_pkg::VERDICT_PROCEED)) |->
			((out_alen_q == '0) && !out_flip_q))
		else $error("failed or skipped write carries a length");
`endif

endmodule

[sv/prng_fault_injector.sv]
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// -------  ---------------------  ------------------------------------------------
// in       in_valid / in_ready    mode, data_byte, final_byte, length
// out      out_valid / out_ready  out_byte, flipped, flip_bit, final_out,
//                                 actual_length, write_verdict
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A byte goes from the test state straight to the result when no bit is
// flipped and through the flip state first when one is; a write plan tests
// the fail, lie and partial thresholds in turn and stops at the first hit.
// A shortened read adds two runs of the 64 x 64 multiplier, which sums
// four 32 x 32 partial products, and a partial write adds one.
// After reset and after every seed write the back expands the seed into the
// four generator words, with two multiplier runs per word; transactions
// are queued meanwhile but not processed.
// The input side only stalls when the command queue is full, and the back
// keeps working while a finished result waits in the output register.

// Fault engine built around a xoshiro256** generator seeded by SplitMix64.
// The front holds the configuration registers and classifies each input
// transaction into a command; a short queue decouples it from the back, which
// draws random values, decides the fault and drives the result register.
module prng_fault_injector #(
	parameter int LENGTH_BITS = 24,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             mode,
	input  logic [7:0]             data_byte,
	input  logic                   final_byte,
	input  logic [LENGTH_BITS-1:0] length,

	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             out_byte,
	output logic                   flipped,
	output logic [2:0]             flip_bit,
	output logic                   final_out,
	output logic [LENGTH_BITS-1:0] actual_length,
	output logic [1:0]             write_verdict,

	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [2:0]             cfg_index,
	input  logic [63:0]            cfg_data
);

	// Width of one queued command: header plus the requested length.
	localparam int CMD_W = $bits(pfi_pkg::cmd_hdr_t) + LENGTH_BITS;

	logic               push;
	logic [CMD_W-1:0]   push_data;
	logic               full;
	logic               pop;
	logic [CMD_W-1:0]   pop_data;
	logic               empty;
	pfi_pkg::cfg_t      cfg;
	pfi_pkg::seed_req_t seed_req;

	// Configuration registers live in the front; a seed write is forwarded
	// to the back as a one-cycle reload request.
	pfi_front #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.length     (length),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.cfg        (cfg),
		.seed_req   (seed_req)
	);

	// Commands wait here while the back is busy with an earlier one.
	pfi_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	// The back owns the generator; every draw advances it by one step, so
	// the order of commands fixes the sequence of faults.
	pfi_back #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.seed_req      (seed_req),
		.empty         (empty),
		.pop           (pop),
		.pop_data      (pop_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.flipped       (flipped),
		.flip_bit      (flip_bit),
		.final_out     (final_out),
		.actual_length (actual_length),
		.write_verdict (write_verdict)
	);

endmodule
